[rtl/sha1sh_pkg.sv]
// ----------------------------------------------------------------------------
// sha1sh_pkg
// Shared types and constants of the byte-stream SHA-1 hasher.
// ----------------------------------------------------------------------------
package sha1sh_pkg;

  // input word: one message byte with its flags
  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_valid;
    logic       last;
  } in_word_t;

  // result word: one digest word
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_word_t;

  // control from the sequencer to the compression datapath
  typedef struct packed {
    logic       init_h;  // reload the chaining words with the initial values
    logic       load;    // copy chaining words into the working registers
    logic       rnd;     // perform one round
    logic       fin;     // add working registers into the chaining words
    logic [6:0] t;       // round number
  } comp_ctl_t;

  localparam int unsigned CHAIN_WORDS = 5;

  localparam logic [31:0] H_INIT [CHAIN_WORDS] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  localparam logic [31:0] K_ROUND [4] = '{
    32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'hca62c1d6
  };

  localparam logic [7:0] PAD_MARK    = 8'h80;
  localparam logic [5:0] LEN_POS     = 6'd56;
  localparam logic [5:0] FILL_LAST   = 6'd63;
  localparam logic [6:0] ROUND_LAST  = 7'd79;
  localparam logic [2:0] WORD_LAST   = 3'd4;
  localparam logic [1:0] BYTE_LAST   = 2'd3;

endpackage

[rtl/sha1sh_wmem.sv]
// ----------------------------------------------------------------------------
// sha1sh_wmem
// Block buffer: sixteen 32-bit big-endian message words, one write port and
// one read port with registered read data.
// ----------------------------------------------------------------------------
module sha1sh_wmem (
  input  logic        clk,
  input  logic        wr_en,
  input  logic [3:0]  wr_addr,
  input  logic [31:0] wr_data,
  input  logic [3:0]  rd_addr,
  output logic [31:0] rd_data
);

  logic [31:0] mem [16];
  logic [31:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/sha1sh_comp.sv]
// ----------------------------------------------------------------------------
// sha1sh_comp
// SHA-1 compression datapath: one round per cycle, 16-word schedule window,
// working registers a..e and the five chaining words.
// ----------------------------------------------------------------------------
module sha1sh_comp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sha1sh_pkg::comp_ctl_t ctl,
  input  logic [31:0]           rd_data,
  input  logic [2:0]            h_sel,
  output logic [31:0]           h_word
);
  import sha1sh_pkg::*;

  logic [31:0] h_r [CHAIN_WORDS];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] ws_r [16];
  logic [31:0] w_x, w_t, f_v, k_v, tmp;

  // message schedule: words 0..15 from the buffer, later ones expanded
  always_comb begin
    w_x = ws_r[13] ^ ws_r[8] ^ ws_r[2] ^ ws_r[0];
    if (ctl.t < 7'd16) begin
      w_t = rd_data;
    end else begin
      w_t = {w_x[30:0], w_x[31]};
    end
  end

  // round function and constant
  always_comb begin
    if (ctl.t < 7'd20) begin
      f_v = (b_r & c_r) | (~b_r & d_r);
      k_v = K_ROUND[0];
    end else if (ctl.t < 7'd40) begin
      f_v = b_r ^ c_r ^ d_r;
      k_v = K_ROUND[1];
    end else if (ctl.t < 7'd60) begin
      f_v = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k_v = K_ROUND[2];
    end else begin
      f_v = b_r ^ c_r ^ d_r;
      k_v = K_ROUND[3];
    end
    tmp = {a_r[26:0], a_r[31:27]} + f_v + e_r + k_v + w_t;
  end

  // working registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a_r <= h_r[0];
      b_r <= h_r[1];
      c_r <= h_r[2];
      d_r <= h_r[3];
      e_r <= h_r[4];
    end else if (ctl.rnd) begin
      a_r <= tmp;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  // schedule window shifts once per round
  always_ff @(posedge clk) begin
    if (ctl.rnd) begin
      for (int i = 0; i < 15; i++) begin
        ws_r[i] <= ws_r[i+1];
      end
      ws_r[15] <= w_t;
    end
  end

  // chaining words
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.init_h) begin
      for (int i = 0; i < CHAIN_WORDS; i++) begin
        h_r[i] <= H_INIT[i];
      end
    end else if (ctl.fin) begin
      h_r[0] <= h_r[0] + a_r;
      h_r[1] <= h_r[1] + b_r;
      h_r[2] <= h_r[2] + c_r;
      h_r[3] <= h_r[3] + d_r;
      h_r[4] <= h_r[4] + e_r;
    end
  end

  // digest word readout
  always_comb begin
    case (h_sel)
      3'd0:    h_word = h_r[0];
      3'd1:    h_word = h_r[1];
      3'd2:    h_word = h_r[2];
      3'd3:    h_word = h_r[3];
      default: h_word = h_r[4];
    endcase
  end

endmodule

[rtl/sha1_stream_hasher_core.sv]
// ----------------------------------------------------------------------------
// sha1_stream_hasher_core
// Byte-stream SHA-1 hasher: collects bytes into blocks, pads the message on
// the final word and returns the five digest words.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one byte per accepted word; byte_valid marks a real message
//           byte, last ends the message (an empty final word is allowed).
//   out_* : five digest words H0..H4 per message, word_index 0..4, last_word
//           set on H4.
// Flow: bytes are taken back to back while in_ready is high; the word that
//   fills a block starts a compression (load, 80 rounds, chaining add), one
//   round per cycle through the compression datapath.
// Padding: after the final word, the pad bytes (9 up to 72) are generated
//   one at a time, and one or two compressions follow before the first
//   digest word appears.
// in_ready is high only while the block waits for message bytes; it is
//   low during compression, padding and digest output.
// A stalled receiver holds the current digest word; nothing is lost.
// Reset restores the initial chaining values, clears the length and fill
//   count; the same happens after the fifth digest word is taken.
// ----------------------------------------------------------------------------
module sha1_stream_hasher_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sha1sh_pkg::in_word_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sha1sh_pkg::out_word_t out_data
);
  import sha1sh_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PAD  = 6'b000010,
    S_LOAD = 6'b000100,
    S_RND  = 6'b001000,
    S_FIN  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  typedef enum logic [2:0] {
    PH_MARK = 3'b001,
    PH_ZERO = 3'b010,
    PH_LEN  = 3'b100
  } phase_t;

  state_t      state_r, state_nxt;
  phase_t      phase_r, phase_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [23:0] wbuf_r, wbuf_nxt;
  logic [63:0] bitlen_r, bitlen_nxt;
  logic [63:0] len_r, len_nxt;
  logic [63:0] bitlen_sum;
  logic [6:0]  t_r, t_nxt;
  logic [2:0]  oidx_r, oidx_nxt;
  logic        pad_act_r, pad_act_nxt;
  logic        final_r, final_nxt;

  logic        put_en;
  logic [7:0]  put_val;
  logic        blk_full;
  logic        wr_en;
  logic [3:0]  wr_addr;
  logic [31:0] wr_data;
  logic [3:0]  rd_addr;
  logic [31:0] rd_data;
  logic [31:0] h_word;
  comp_ctl_t   ctl;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  assign bitlen_sum = bitlen_r + (in_data.byte_valid ? 64'd8 : 64'd0);

  // byte source: input byte or generated pad byte
  always_comb begin
    put_en  = 1'b0;
    put_val = in_data.msg_byte;
    if (state_r == S_IDLE) begin
      put_en = in_valid && in_data.byte_valid;
    end else if (state_r == S_PAD) begin
      unique case (phase_r)
        PH_MARK: begin
          put_en  = 1'b1;
          put_val = PAD_MARK;
        end
        PH_ZERO: begin
          put_en  = (fill_r != LEN_POS);
          put_val = 8'h00;
        end
        PH_LEN: begin
          put_en  = 1'b1;
          put_val = len_r[{~fill_r[2:0], 3'b000} +: 8];
        end
        default: begin
          put_en  = 1'b0;
          put_val = 8'h00;
        end
      endcase
    end
  end

  // word packer and buffer write
  always_comb begin
    wbuf_nxt = wbuf_r;
    fill_nxt = fill_r;
    wr_en    = 1'b0;
    wr_addr  = fill_r[5:2];
    wr_data  = {wbuf_r, put_val};
    blk_full = put_en && (fill_r == FILL_LAST);
    if (put_en) begin
      fill_nxt = fill_r + 6'd1;
      if (fill_r[1:0] == BYTE_LAST) begin
        wr_en = 1'b1;
      end else begin
        wbuf_nxt = {wbuf_r[15:0], put_val};
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    bitlen_nxt  = bitlen_r;
    len_nxt     = len_r;
    t_nxt       = t_r;
    oidx_nxt    = oidx_r;
    pad_act_nxt = pad_act_r;
    final_nxt   = final_r;
    rd_addr     = t_r[3:0] + 4'd1;
    ctl         = '0;
    ctl.t       = t_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          bitlen_nxt = bitlen_sum;
          if (in_data.last) begin
            pad_act_nxt = 1'b1;
            phase_nxt   = PH_MARK;
            len_nxt     = bitlen_sum;
          end
          if (blk_full) begin
            state_nxt = S_LOAD;
          end else if (in_data.last) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        unique case (phase_r)
          PH_MARK: phase_nxt = PH_ZERO;
          PH_ZERO: begin
            if (fill_r == LEN_POS) begin
              phase_nxt = PH_LEN;
            end
          end
          PH_LEN:  phase_nxt = PH_LEN;
          default: phase_nxt = PH_MARK;
        endcase
        if (blk_full) begin
          state_nxt = S_LOAD;
          if (phase_r == PH_LEN) begin
            final_nxt = 1'b1;
          end
        end
      end
      S_LOAD: begin
        ctl.load  = 1'b1;
        rd_addr   = 4'd0;
        t_nxt     = 7'd0;
        state_nxt = S_RND;
      end
      S_RND: begin
        ctl.rnd = 1'b1;
        t_nxt   = t_r + 7'd1;
        if (t_r == ROUND_LAST) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        ctl.fin = 1'b1;
        if (final_r) begin
          state_nxt = S_OUT;
          oidx_nxt  = 3'd0;
        end else if (pad_act_r) begin
          state_nxt = S_PAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          if (oidx_r == WORD_LAST) begin
            ctl.init_h  = 1'b1;
            bitlen_nxt  = 64'd0;
            pad_act_nxt = 1'b0;
            final_nxt   = 1'b0;
            state_nxt   = S_IDLE;
          end else begin
            oidx_nxt = oidx_r + 3'd1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      phase_r   <= PH_MARK;
      fill_r    <= '0;
      bitlen_r  <= '0;
      t_r       <= '0;
      oidx_r    <= '0;
      pad_act_r <= 1'b0;
      final_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      phase_r   <= phase_nxt;
      fill_r    <= fill_nxt;
      bitlen_r  <= bitlen_nxt;
      t_r       <= t_nxt;
      oidx_r    <= oidx_nxt;
      pad_act_r <= pad_act_nxt;
      final_r   <= final_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    wbuf_r <= wbuf_nxt;
    len_r  <= len_nxt;
  end

  sha1sh_wmem u_wmem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sha1sh_comp u_comp (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .rd_data (rd_data),
    .h_sel   (oidx_r),
    .h_word  (h_word)
  );

  // digest output
  assign out_data.digest_word = h_word;
  assign out_data.word_index  = oidx_r;
  assign out_data.last_word   = (oidx_r == WORD_LAST);

  // checks
  a_no_write_in_comp: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_IDLE || state_r == S_PAD))
    else $error("buffer written outside byte intake");

  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RND && t_r == ROUND_LAST) |=> (state_r == S_FIN))
    else $error("compression did not finish after last round");

  a_block_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |-> (fill_r == 6'd0))
    else $error("compression started on a partly filled block");

  a_digest_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && oidx_r == WORD_LAST) |=>
      (state_r == S_IDLE && bitlen_r == 64'd0 && fill_r == 6'd0))
    else $error("state not restored after digest");

endmodule
